// ----- src/b64enc_pkg.sv -----
// ----------------------------------------------------------------------------
// b64enc_pkg: shared types and helpers for the base64 stream encoder
// Group record passed from the byte collector to the character serializer,
// queue sizing, and the base64 alphabet lookup.
// ----------------------------------------------------------------------------
package b64enc_pkg;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] PAD_CHAR = 8'h3D;

   // Number of real bytes in a group (1..3).
   localparam logic [1:0] NVALID_ONE   = 2'd1;
   localparam logic [1:0] NVALID_TWO   = 2'd2;
   localparam logic [1:0] NVALID_THREE = 2'd3;

   // Position of a character within its group of four.
   localparam logic [1:0] CHAR_POS_0 = 2'd0;
   localparam logic [1:0] CHAR_POS_1 = 2'd1;
   localparam logic [1:0] CHAR_POS_2 = 2'd2;
   localparam logic [1:0] CHAR_POS_3 = 2'd3;

   typedef struct packed {
      logic [7:0] b0;
      logic [7:0] b1;
      logic [7:0] b2;
      logic [1:0] nvalid;
   } group_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Standard alphabet: A-Z, a-z, 0-9, '+', '/'.
   function automatic logic [7:0] alphabet(input logic [5:0] v);
      logic [7:0] c;
      if (v < 6'd26) begin
         c = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         c = 8'h61 + ({2'b00, v} - 8'd26);
      end else if (v < 6'd62) begin
         c = 8'h30 + ({2'b00, v} - 8'd52);
      end else if (v == 6'd62) begin
         c = 8'h2B;
      end else begin
         c = 8'h2F;
      end
      return c;
   endfunction

   // Character at position pos of a group, with padding applied.
   function automatic logic [7:0] group_char(input group_type g, input logic [1:0] pos);
      logic [5:0] sextet;
      logic       pad;
      sextet = 6'd0;
      pad    = 1'b0;
      case (pos)
         CHAR_POS_0: sextet = g.b0[7:2];
         CHAR_POS_1: sextet = {g.b0[1:0], g.b1[7:4]};
         CHAR_POS_2: begin
            sextet = {g.b1[3:0], g.b2[7:6]};
            pad    = (g.nvalid < NVALID_TWO);
         end
         default: begin
            sextet = g.b2[5:0];
            pad    = (g.nvalid < NVALID_THREE);
         end
      endcase
      return pad ? PAD_CHAR : alphabet(sextet);
   endfunction

endpackage

// ----- src/b64enc_front.sv -----
// ----------------------------------------------------------------------------
// b64enc_front: byte collector
// Accepts bytes, holds up to two pending bytes and pushes a complete or
// flushed group into the queue.
// ----------------------------------------------------------------------------
module b64enc_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [7:0]                    req_data_byte,
   input  logic                          req_last,
   input  b64enc_pkg::queue_status_type  queue_status,
   output logic                          push,
   output b64enc_pkg::group_type         push_group
);

   logic [15:0] held_bytes_ff, held_bytes_in;
   logic [1:0]  held_count_ff, held_count_in;
   logic        accept;

   assign req_stall = queue_status.full;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      held_bytes_in = held_bytes_ff;
      held_count_in = held_count_ff;
      push          = 1'b0;
      push_group    = '0;
      if (accept) begin
         case (held_count_ff)
            2'd2: begin
               push          = 1'b1;
               push_group    = '{b0: held_bytes_ff[15:8], b1: held_bytes_ff[7:0],
                                 b2: req_data_byte, nvalid: b64enc_pkg::NVALID_THREE};
               held_bytes_in = '0;
               held_count_in = 2'd0;
            end
            2'd1: begin
               if (req_last) begin
                  push          = 1'b1;
                  push_group    = '{b0: held_bytes_ff[15:8], b1: req_data_byte,
                                    b2: 8'd0, nvalid: b64enc_pkg::NVALID_TWO};
                  held_bytes_in = '0;
                  held_count_in = 2'd0;
               end else begin
                  held_bytes_in = {held_bytes_ff[15:8], req_data_byte};
                  held_count_in = 2'd2;
               end
            end
            default: begin
               if (req_last) begin
                  push          = 1'b1;
                  push_group    = '{b0: req_data_byte, b1: 8'd0,
                                    b2: 8'd0, nvalid: b64enc_pkg::NVALID_ONE};
                  held_bytes_in = '0;
                  held_count_in = 2'd0;
               end else begin
                  held_bytes_in = {req_data_byte, 8'd0};
                  held_count_in = 2'd1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_bytes_ff <= '0;
         held_count_ff <= '0;
      end else begin
         held_bytes_ff <= held_bytes_in;
         held_count_ff <= held_count_in;
      end
   end

endmodule

// ----- src/b64enc_queue.sv -----
// ----------------------------------------------------------------------------
// b64enc_queue: group queue
// Short first-in first-out buffer of group records between collector and
// serializer.
// ----------------------------------------------------------------------------
module b64enc_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  b64enc_pkg::group_type         push_group,
   input  logic                          pop,
   output b64enc_pkg::group_type         pop_group,
   output b64enc_pkg::queue_status_type  status
);

   b64enc_pkg::group_type                 entry_ff [b64enc_pkg::QUEUE_DEPTH];
   logic [b64enc_pkg::QPTR_W-1:0]          wr_ptr_ff, wr_ptr_in;
   logic [b64enc_pkg::QPTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic [b64enc_pkg::QCNT_W-1:0]          count_ff, count_in;
   logic                                   do_push, do_pop;

   assign status.full  = (count_ff == b64enc_pkg::QCNT_W'(b64enc_pkg::QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_group    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_group;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- src/b64enc_back.sv -----
// ----------------------------------------------------------------------------
// b64enc_back: character serializer
// Takes one group at a time from the queue and emits its four characters
// through a registered output stage.
// ----------------------------------------------------------------------------
module b64enc_back (
   input  logic                          clock,
   input  logic                          reset,
   input  b64enc_pkg::queue_status_type  queue_status,
   input  b64enc_pkg::group_type         pop_group,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_out_char,
   output logic                          rsp_last_char
);

   b64enc_pkg::group_type group_ff, group_in;
   logic                  busy_ff, busy_in;
   logic [1:0]            pos_ff, pos_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [7:0]            rsp_out_char_ff, rsp_out_char_in;
   logic                  rsp_last_char_ff, rsp_last_char_in;
   logic                  out_free;
   logic                  group_done;

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign group_done = !busy_ff || (pos_ff == b64enc_pkg::CHAR_POS_3);
   assign pop        = out_free && group_done && !queue_status.empty;

   always_comb begin
      group_in         = group_ff;
      busy_in          = busy_ff;
      pos_in           = pos_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_out_char_in  = rsp_out_char_ff;
      rsp_last_char_in = rsp_last_char_ff;
      if (out_free) begin
         rsp_valid_in = busy_ff;
         if (busy_ff) begin
            rsp_out_char_in  = b64enc_pkg::group_char(group_ff, pos_ff);
            rsp_last_char_in = (pos_ff == b64enc_pkg::CHAR_POS_3);
            pos_in           = pos_ff + 1'b1;
         end
         if (group_done) begin
            busy_in  = !queue_status.empty;
            group_in = pop_group;
            pos_in   = b64enc_pkg::CHAR_POS_0;
         end
      end
   end

   always_ff @(posedge clock) begin
      group_ff         <= group_in;
      rsp_out_char_ff  <= rsp_out_char_in;
      rsp_last_char_ff <= rsp_last_char_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_char  = rsp_out_char_ff;
   assign rsp_last_char = rsp_last_char_ff;

endmodule

// ----- src/base64_stream_encoder.sv -----
// ----------------------------------------------------------------------------
// base64_stream_encoder: streaming base64 encoder (standard alphabet)
// Path: a completed or flushed group is written to the queue, loaded into the
//   group register, then its first character is registered on the output
//   (back side idle); the other three follow one per cycle while not stalled.
// Throughput: one byte per cycle while the group queue has room; sustained
//   rate is set by the one-character output port, four characters per group.
// Reset: synchronous, active high; clears pending bytes, queue and output.
// ----------------------------------------------------------------------------
module base64_stream_encoder (
   input  logic       clock,
   input  logic       reset,
   // byte transactions
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_last,
   // character transactions
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_last_char
);

   // Front side: collect bytes into groups of up to three.
   // Queue: hold finished groups so the front keeps taking bytes while the
   //        back side drains characters.
   // Back side: turn each group into four characters, padding with '='.

   b64enc_pkg::queue_status_type queue_status;
   b64enc_pkg::group_type        push_group;
   b64enc_pkg::group_type        pop_group;
   logic                         push;
   logic                         pop;

   b64enc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last      (req_last),
      .queue_status  (queue_status),
      .push          (push),
      .push_group    (push_group)
   );

   b64enc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_group (push_group),
      .pop        (pop),
      .pop_group  (pop_group),
      .status     (queue_status)
   );

   b64enc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_status  (queue_status),
      .pop_group     (pop_group),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for base64_stream_encoder
// Drives byte transactions (directed corner groups, then random messages),
// predicts every character from a local model of the byte collector, and
// compares each character transaction in order. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;

   localparam int CLOCK_PERIOD = 12;
   localparam int TOTAL_ITEMS  = 130;
   localparam int CALM_FROM    = 100;      // no idling once this many bytes are in
   localparam int CYCLE_LIMIT  = 100000;
   localparam int MAX_REPORTS  = 10;
   localparam int SETTLE_CYCLES = 20;      // covers the encoder latency plus a group

   // Standard alphabet, first character in the top byte.
   localparam bit [8*64-1:0] B64_CHARS =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   typedef struct packed {
      bit [7:0] ch;
      bit       last;
   } b64_char_type;

   // -------------------------------------------------------------------------
   // Scoreboard: local encoder model plus the queue of pending characters
   // -------------------------------------------------------------------------
   class char_scoreboard;
      bit [15:0]    held_pair;
      bit [1:0]     held_num;
      b64_char_type pending_chars[$];
      int           error_count;

      function void queue_group(bit [7:0] b0, bit [7:0] b1, bit [7:0] b2, int real_bytes);
         bit [23:0]    word;
         bit [5:0]     sextet;
         b64_char_type c;
         word = {b0, b1, b2};
         for (int k = 0; k < 4; k++) begin
            sextet = word[23 - 6*k -: 6];
            c.ch   = (k > real_bytes) ? b64enc_pkg::PAD_CHAR
                                      : B64_CHARS[8*(63 - sextet) +: 8];
            c.last = (k == 3);
            pending_chars.push_back(c);
         end
         held_pair = '0;
         held_num  = '0;
      endfunction

      // Advance the model by one accepted byte transaction.
      function void note_byte(bit [7:0] b, bit fin);
         case (held_num)
            2'd1: begin
               if (fin) begin
                  queue_group(held_pair[15:8], b, 8'h00, 2);
               end else begin
                  held_pair[7:0] = b;
                  held_num       = 2'd2;
               end
            end
            2'd2: begin
               queue_group(held_pair[15:8], held_pair[7:0], b, 3);
            end
            default: begin
               if (fin) begin
                  queue_group(b, 8'h00, 8'h00, 1);
               end else begin
                  held_pair = {b, 8'h00};
                  held_num  = 2'd1;
               end
            end
         endcase
      endfunction

      // Compare one accepted character transaction against the oldest prediction.
      function void check_char(bit [7:0] ch, bit lastc);
         b64_char_type want;
         if (pending_chars.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("unexpected character: char %h last %b", ch, lastc);
            return;
         end
         want = pending_chars.pop_front();
         if (want.ch !== ch || want.last !== lastc) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("mismatch: expected char %h last %b, got char %h last %b",
                        want.ch, want.last, ch, lastc);
         end
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and block
   // -------------------------------------------------------------------------
   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_out_char;
   logic       rsp_last_char;

   char_scoreboard sb = new();

   int items_sent  = 0;
   int cycle_count = 0;
   int gap_pct     = 25;   // chance in percent of a sender gap after a byte
   int stall_pct   = 12;   // chance in percent of a receiver stall burst
   int stall_left  = 0;
   bit calm        = 1'b0; // set for the tail of the run: no idling on either side

   initial begin
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   base64_stream_encoder DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

   // -------------------------------------------------------------------------
   // Sender side
   // -------------------------------------------------------------------------

   // Present one byte, hold it until the block takes it, then maybe idle.
   // Valid stays high between back-to-back bytes, so it is never lowered and
   // raised again in one step.
   task automatic send_byte(input bit [7:0] b, input bit fin);
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last      <= fin;
      do @(posedge clock); while (req_stall);
      sb.note_byte(b, fin);
      items_sent++;
      if (!calm && $urandom_range(0, 99) < gap_pct) begin
         req_valid     <= 1'b0;
         req_data_byte <= 8'($urandom_range(0, 255));
         req_last      <= 1'($urandom_range(0, 1));
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // Hold off until every predicted character has come out; always idle before
   // returning so valid is not driven twice in one step.
   task automatic wait_drain();
      do @(posedge clock); while (sb.pending_chars.size() != 0);
   endtask

   // -------------------------------------------------------------------------
   // Receiver side: check on acceptance, stall in random bursts
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall)
            sb.check_char(rsp_out_char, rsp_last_char);
         if (stall_left != 0) begin
            stall_left--;
            if (stall_left == 0)
               rsp_stall <= 1'b0;
         end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
            rsp_stall  <= 1'b1;
            stall_left = $urandom_range(1, 16);
         end
      end
   end

   // Watchdog: end the run if it hangs.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------
   initial begin
      int  msg_len;
      bit  noisy;
      bit  open_end;
      bit  fin;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed groups. One byte with last: two chars and double pad.
      send_byte(8'h00, 1'b1);               // AA==
      send_byte(8'hFF, 1'b1);               // /w==
      // Two bytes with last: three chars and single pad.
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);               // //8=
      send_byte(8'h00, 1'b0);
      send_byte(8'h80, 1'b1);               // AIA=
      // Full group without last, then with last on the third byte.
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b0);               // ////
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);               // AAAA
      send_byte(8'hFB, 1'b0);
      send_byte(8'hEF, 1'b0);
      send_byte(8'hBE, 1'b1);               // ++++
      send_byte(8'h4D, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h6E, 1'b0);               // TWFu
      send_byte(8'h55, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h3C, 1'b1);               // alternating bits in the first two bytes

      // Drop the sender until the block has emptied out.
      req_valid <= 1'b0;
      wait_drain();

      // Random messages: mostly well formed with the flag on the final byte,
      // some left open, some with the flag scattered at random.
      while (items_sent < TOTAL_ITEMS) begin
         if (items_sent >= CALM_FROM) calm = 1'b1;
         case ($urandom_range(0, 2))
            0: gap_pct = 0;
            1: gap_pct = 25;
            default: gap_pct = 60;
         endcase
         case ($urandom_range(0, 2))
            0: stall_pct = 0;
            1: stall_pct = 12;
            default: stall_pct = 40;
         endcase
         msg_len  = $urandom_range(1, 9);
         noisy    = ($urandom_range(0, 6) == 0);
         open_end = ($urandom_range(0, 4) == 0);
         for (int i = 0; i < msg_len; i++) begin
            if (noisy)
               fin = ($urandom_range(0, 3) == 0);
            else
               fin = !open_end && (i == msg_len - 1);
            send_byte(8'($urandom_range(0, 255)), fin);
         end
         if (!calm && $urandom_range(0, 9) == 0) begin
            req_valid <= 1'b0;
            wait_drain();
         end
      end

      req_valid <= 1'b0;
      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (sb.error_count == 0 && sb.pending_chars.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
src/b64enc_pkg.sv
src/b64enc_front.sv
src/b64enc_queue.sv
src/b64enc_back.sv
src/base64_stream_encoder.sv
verif/testbench.sv
